### rtl/skhs_pkg.sv
// ----------------------------------------------------------------------------
// skhs_pkg
// Shared types and codes of the string key hash store.
// ----------------------------------------------------------------------------
`default_nettype none
package skhs_pkg;
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_POOL_FULL = 3'd4;
	localparam logic [2:0] ST_TOO_LONG  = 3'd5;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam int unsigned HASH_SEED = 5381;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_HEAD,
		FSM_ENTRY,
		FSM_CMP,
		FSM_WRITE,
		FSM_CLEAR,
		FSM_DONE
	} fsm_t;
endpackage
`default_nettype wire

### rtl/string_key_hash_store_core.sv
// ----------------------------------------------------------------------------
// string_key_hash_store_core
// Chained hash table keyed by zero-terminated byte strings (djb2 bucket hash).
// ----------------------------------------------------------------------------
//  channel  | signals                                | transfer
//  input    | start, busy, action, key_byte, value   | start && !busy
//  result   | done, status, found_value, entry_count | done high, one cycle
//
// Nonzero key bytes are taken while idle and leave busy low. A terminator
// holds busy while the bucket head is read, each chain entry is compared
// byte by byte and, on insert, the new key is copied into the pool; an
// overlong key holds busy only for the done state.
// done marks the first idle cycle after an operation.
// After reset, the bucket head memory is cleared entry by entry while busy is high.
// Results cannot be stalled.
`default_nettype none
module string_key_hash_store_core #(
	parameter int BUCKETS       = 64,
	parameter int MAX_KEY_BYTES = 32,
	parameter int POOL_ENTRIES  = 256
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        start,
	output logic              busy,
	input  wire  logic        action,
	input  wire  logic [7:0]  key_byte,
	input  wire  logic signed [31:0] value,
	output logic              done,
	output logic [2:0]        status,
	output logic signed [31:0] found_value,
	output logic [8:0]        entry_count
);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int KW = $clog2(MAX_KEY_BYTES);
	localparam int EW = $clog2(POOL_ENTRIES);
	localparam int LW = EW + 1;

	// memories
	logic [7:0]    kbuf_mem [MAX_KEY_BYTES];
	logic [LW-1:0] head_mem [BUCKETS];
	logic [7:0]    skey_mem [POOL_ENTRIES*MAX_KEY_BYTES];
	logic [KW-1:0] slen_mem [POOL_ENTRIES];
	logic [31:0]   sval_mem [POOL_ENTRIES];
	logic [LW-1:0] link_mem [POOL_ENTRIES];

	skhs_pkg::fsm_t state_q, state_d;
	logic [KW-1:0] klen_q;
	logic          kovf_q;
	logic [BW-1:0] hash_q, bucket_q;
	logic [LW-1:0] used_q, cur_q, steps_q, head_q;
	logic [KW:0]   idx_q;
	logic          act_q;
	logic [31:0]   val_q;
	logic [BW-1:0] clr_q;
	logic [2:0]    st_q;
	logic [31:0]   fv_q;
	logic          done_q;

	logic [7:0]    kbuf_rd, skey_rd;
	logic [KW-1:0] slen_rd;
	logic [31:0]   sval_rd;
	logic [LW-1:0] head_rd, link_rd;
	logic [KW-1:0] kidx;
	logic [BW-1:0] seed;
	logic [BW+6:0] hmul;
	logic          accept, is_byte, is_term, walk_ok, cmp_end;

	assign seed    = BW'(skhs_pkg::HASH_SEED);
	assign accept  = start && !busy;
	assign is_byte = accept && (key_byte != 8'd0);
	assign is_term = accept && (key_byte == 8'd0);
	assign hmul    = {7'd0, hash_q} * (BW+7)'(33) + (BW+7)'(key_byte);
	assign kidx    = idx_q[KW-1:0];
	assign walk_ok = (cur_q < used_q) && (steps_q < used_q);
	assign cmp_end = (idx_q[KW:0] == {1'b0, klen_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			skhs_pkg::FSM_CLEAR: if (clr_q == BW'(BUCKETS-1)) state_d = skhs_pkg::FSM_IDLE;
			skhs_pkg::FSM_IDLE:  if (is_term) state_d = kovf_q ? skhs_pkg::FSM_DONE
			                                                  : skhs_pkg::FSM_HEAD;
			skhs_pkg::FSM_HEAD:  state_d = skhs_pkg::FSM_ENTRY;
			skhs_pkg::FSM_ENTRY: begin
				if (!walk_ok) begin
					state_d = (act_q == skhs_pkg::ACT_INSERT && used_q < LW'(POOL_ENTRIES))
					          ? skhs_pkg::FSM_WRITE : skhs_pkg::FSM_DONE;
				end else begin
					state_d = skhs_pkg::FSM_CMP;
				end
			end
			skhs_pkg::FSM_CMP: begin
				if (slen_rd != klen_q) state_d = skhs_pkg::FSM_ENTRY;
				else if (idx_q != '0 && kbuf_rd != skey_rd) state_d = skhs_pkg::FSM_ENTRY;
				else if (cmp_end) state_d = skhs_pkg::FSM_DONE;
			end
			skhs_pkg::FSM_WRITE: if (cmp_end) state_d = skhs_pkg::FSM_DONE;
			skhs_pkg::FSM_DONE:  state_d = skhs_pkg::FSM_IDLE;
			default: state_d = skhs_pkg::FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		case (state_q)
			skhs_pkg::FSM_IDLE: busy = 1'b0;
			default:            busy = 1'b1;
		endcase
	end

	assign done        = done_q;
	assign status      = st_q;
	assign found_value = fv_q;
	assign entry_count = 9'(used_q);

	// key byte buffer and heads memory
	always_ff @(posedge clk) begin
		if (is_byte && klen_q != KW'(MAX_KEY_BYTES-1)) kbuf_mem[klen_q] <= key_byte;
		kbuf_rd <= kbuf_mem[kidx];
		if (state_q == skhs_pkg::FSM_CLEAR) head_mem[clr_q] <= LW'(POOL_ENTRIES);
		else if (state_q == skhs_pkg::FSM_WRITE && idx_q == '0)
			head_mem[bucket_q] <= used_q;
		head_rd <= head_mem[hash_q];
	end

	// entry pool memories; the walk addresses cur_q, the insert used_q
	always_ff @(posedge clk) begin
		if (state_q == skhs_pkg::FSM_WRITE) begin
			if (idx_q != '0) skey_mem[{used_q[EW-1:0], KW'(idx_q - 1'b1)}] <= kbuf_rd;
			if (idx_q == '0) begin
				slen_mem[used_q[EW-1:0]] <= klen_q;
				sval_mem[used_q[EW-1:0]] <= val_q;
				link_mem[used_q[EW-1:0]] <= head_q;
			end
		end
		skey_rd <= skey_mem[{cur_q[EW-1:0], kidx}];
		slen_rd <= slen_mem[cur_q[EW-1:0]];
		sval_rd <= sval_mem[cur_q[EW-1:0]];
		link_rd <= link_mem[cur_q[EW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= skhs_pkg::FSM_CLEAR;
			klen_q   <= '0;
			kovf_q   <= 1'b0;
			hash_q   <= seed;
			used_q   <= '0;
			clr_q    <= '0;
			done_q   <= 1'b0;
			idx_q    <= '0;
			cur_q    <= '0;
			steps_q  <= '0;
			head_q   <= '0;
			bucket_q <= '0;
			act_q    <= skhs_pkg::ACT_INSERT;
			val_q    <= '0;
			st_q     <= skhs_pkg::ST_INSERTED;
			fv_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				skhs_pkg::FSM_CLEAR: clr_q <= clr_q + 1'b1;
				skhs_pkg::FSM_IDLE: begin
					if (is_byte) begin
						if (klen_q != KW'(MAX_KEY_BYTES-1)) begin
							klen_q <= klen_q + 1'b1;
							hash_q <= hmul[BW-1:0];
						end else begin
							kovf_q <= 1'b1;
						end
					end
					if (is_term) begin
						bucket_q <= hash_q;
						act_q    <= action;
						val_q    <= value;
						steps_q  <= '0;
						st_q     <= skhs_pkg::ST_TOO_LONG;
						fv_q     <= '0;
					end
				end
				skhs_pkg::FSM_HEAD: begin
					cur_q  <= head_rd;
					head_q <= head_rd;
					idx_q  <= '0;
				end
				skhs_pkg::FSM_ENTRY: begin
					idx_q <= '0;
					if (!walk_ok) begin
						st_q <= (act_q == skhs_pkg::ACT_LOOKUP) ? skhs_pkg::ST_NOT_FOUND
						      : (used_q < LW'(POOL_ENTRIES)) ? skhs_pkg::ST_INSERTED
						      : skhs_pkg::ST_POOL_FULL;
					end
				end
				skhs_pkg::FSM_CMP: begin
					// byte idx-1 compares while idx is fetched
					if (slen_rd != klen_q || (idx_q != '0 && kbuf_rd != skey_rd)) begin
						cur_q   <= link_rd;
						steps_q <= steps_q + 1'b1;
					end else if (cmp_end) begin
						st_q <= (act_q == skhs_pkg::ACT_LOOKUP) ? skhs_pkg::ST_FOUND
						                                        : skhs_pkg::ST_DUPLICATE;
						fv_q <= (act_q == skhs_pkg::ACT_LOOKUP) ? sval_rd : 32'd0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				skhs_pkg::FSM_WRITE: begin
					idx_q <= idx_q + 1'b1;
					if (cmp_end) used_q <= used_q + 1'b1;
				end
				skhs_pkg::FSM_DONE: begin
					done_q <= 1'b1;
					klen_q <= '0;
					kovf_q <= 1'b0;
					hash_q <= seed;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/skhs_checker.sv
// ----------------------------------------------------------------------------
// skhs_checker
// Port-level checks for the string key hash store.
// ----------------------------------------------------------------------------
`default_nettype none
module skhs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [2:0] status,
	input wire logic [31:0] found_value,
	input wire logic [8:0] entry_count
);
	// no two results back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("back to back results");
	// a count change seen with a result needs an insert status
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(entry_count) != entry_count |-> status == skhs_pkg::ST_INSERTED)
		else $error("count moved without insert");
	// found value is zero unless found
	a_fv: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != skhs_pkg::ST_FOUND |-> found_value == 32'd0)
		else $error("stray found value");
	// idle after a result
	a_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("busy with result");
	// status in range
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= skhs_pkg::ST_TOO_LONG)
		else $error("bad status");
endmodule
bind string_key_hash_store_core skhs_checker u_chk (.*);
`default_nettype wire
